// File: hw/rtl/bdq_pkg.sv
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int RSP_COUNT_W   = 5;
   localparam int VALUE_W       = 32;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_CONTAINS   = 3'd4,
      FUNC_REMOVE     = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic                      found;
      logic [RSP_COUNT_W-1:0]    count;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                      go;
      func_type                  op;
      logic [VALUE_W-1:0]        value;
      logic                      full;
      logic                      empty;
   } cell_ctl_type;

   // where a cell sits relative to the current fill level
   typedef struct packed {
      logic occupied;
      logic at_tail;
      logic is_last;
   } cell_pos_type;

endpackage

// File: hw/rtl/bdq_cell.sv
module bdq_cell
   import bdq_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  cell_pos_type       pos,
   input  logic [VALUE_W-1:0] left_value,
   input  logic [VALUE_W-1:0] right_value,
   input  logic               seen_in,
   output logic               seen_out,
   input  logic [VALUE_W-1:0] back_in,
   output logic [VALUE_W-1:0] back_out,
   output logic [VALUE_W-1:0] value_out
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   assign seen_out  = seen_in | (pos.occupied && (value_ff == ctl.value));
   assign back_out  = back_in | (pos.is_last ? value_ff : '0);
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.go) begin
         unique case (ctl.op)
            FUNC_PUSH_FRONT: begin
               if (!ctl.full) value_in = left_value;
            end
            FUNC_PUSH_BACK: begin
               if (!ctl.full && pos.at_tail) value_in = ctl.value;
            end
            FUNC_POP_FRONT: begin
               if (!ctl.empty) value_in = right_value;
            end
            FUNC_REMOVE: begin
               if (seen_out) value_in = right_value;
            end
            default: begin
               value_in = value_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: hw/rtl/bounded_deque_bag.sv
// Bounded double-ended queue that also works as a bag. The values sit in a
// row of DEPTH cells in queue order, front in the first cell; every cell
// compares its value with the request at once and shifts toward a neighbor.
// A word is taken on any edge with start high (busy stays low), and its
// result appears on rsp_data with rsp_strobe high for exactly one cycle, the
// cycle after the word was taken. The receiver cannot stall: a result must
// be captured in its cycle. A new word may be given every cycle. The
// result's count field holds the low five bits of the fill level.
module bounded_deque_bag
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               strobe_ff;
   status_type         status_ff;
   status_type         status_in;
   logic               found_ff;
   logic               found_in;

   cell_ctl_type       ctl;
   logic               full;
   logic               empty;
   logic [DEPTH:0]     seen;
   logic [VALUE_W-1:0] back [DEPTH+1];
   logic [VALUE_W-1:0] cell_value [DEPTH];

   assign busy  = 1'b0;
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   assign ctl.go    = start;
   assign ctl.op    = func_type'(req_data.func);
   assign ctl.value = req_data.value;
   assign ctl.full  = full;
   assign ctl.empty = empty;

   assign seen[0] = 1'b0;
   assign back[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_pos_type       pos;
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;

      assign pos.occupied = (CW'(i) < count_ff);
      assign pos.at_tail  = (count_ff == CW'(i));
      assign pos.is_last  = (count_ff == CW'(i + 1));

      if (i == 0) begin : g_first
         assign left_value = req_data.value;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      bdq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (pos),
         .left_value  (left_value),
         .right_value (right_value),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .back_in     (back[i]),
         .back_out    (back[i+1]),
         .value_out   (cell_value[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      found_in  = 1'b0;
      unique case (ctl.op) inside
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (full) status_in = STATUS_FULL;
            else      count_in  = count_ff + CW'(1);
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (empty) status_in = STATUS_EMPTY;
            else       count_in  = count_ff - CW'(1);
         end
         FUNC_CONTAINS: begin
            found_in = seen[DEPTH];
            if (!seen[DEPTH]) status_in = STATUS_NOT_FOUND;
         end
         FUNC_REMOVE: begin
            found_in = seen[DEPTH];
            if (seen[DEPTH]) count_in  = count_ff - CW'(1);
            else             status_in = STATUS_NOT_FOUND;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= start;
         if (start) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   // result reads the state left by the word taken on the previous edge
   assign rsp_strobe           = strobe_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.found       = found_ff;
   assign rsp_data.count       = RSP_COUNT_W'(count_ff);
   assign rsp_data.front_value = empty ? '0 : cell_value[0];
   assign rsp_data.back_value  = back[DEPTH];

endmodule

// File: sim/bounded_deque_bag_check.sv
module bounded_deque_bag_check
   import bdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = DEPTH_DEFAULT;

   // front of the deque at index 0
   logic [VALUE_W-1:0] stored_values[$];
   rsp_type            expected_rsp[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int first_copy(input logic [VALUE_W-1:0] v);
      for (int i = 0; i < stored_values.size(); i++) begin
         if (stored_values[i] == v) return i;
      end
      return -1;
   endfunction

   task automatic apply_word(input req_type word, output rsp_type result);
      int pos;
      result        = '0;
      result.status = STATUS_OK;
      case (word.func) inside
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (stored_values.size() >= CAPACITY) begin
               result.status = STATUS_FULL;
            end else if (word.func == FUNC_PUSH_FRONT) begin
               stored_values.push_front(word.value);
            end else begin
               stored_values.push_back(word.value);
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (stored_values.size() == 0) begin
               result.status = STATUS_EMPTY;
            end else if (word.func == FUNC_POP_FRONT) begin
               void'(stored_values.pop_front());
            end else begin
               void'(stored_values.pop_back());
            end
         end
         FUNC_CONTAINS, FUNC_REMOVE: begin
            pos = first_copy(word.value);
            if (pos < 0) begin
               result.status = STATUS_NOT_FOUND;
            end else begin
               result.found = 1'b1;
               if (word.func == FUNC_REMOVE) stored_values.delete(pos);
            end
         end
         default: begin
         end
      endcase
      result.count = RSP_COUNT_W'(stored_values.size());
      if (stored_values.size() != 0) begin
         result.front_value = stored_values[0];
         result.back_value  = stored_values[stored_values.size() - 1];
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type next_rsp;
      if (reset) begin
         stored_values.delete();
         expected_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_data.status), 32'hx);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
               if (rsp_data.count !== want.count)
                  report_mismatch("count", 32'(rsp_data.count), 32'(want.count));
               if (rsp_data.front_value !== want.front_value)
                  report_mismatch("front_value", rsp_data.front_value, want.front_value);
               if (rsp_data.back_value !== want.back_value)
                  report_mismatch("back_value", rsp_data.back_value, want.back_value);
            end
         end
         if (start && !busy) begin
            apply_word(req_data, next_rsp);
            expected_rsp.push_back(next_rsp);
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

// File: sim/bounded_deque_bag_test.sv
module bounded_deque_bag_test;
   import bdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_RESERVED_6 = 3'd6;
   localparam logic [2:0] FUNC_RESERVED_7 = 3'd7;
   localparam int ITEMS_PER_PHASE = 325;
   localparam int CYCLE_LIMIT     = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   int      idle_pct;

   logic [VALUE_W-1:0] value_pool[8];

   bounded_deque_bag dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   bounded_deque_bag_check checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bounded_deque_bag regression: fail");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [2:0] func, input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_data.func  = func;
      req_data.value = value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_func(input bit filling);
      int w;
      w = $urandom_range(99);
      if (filling) begin
         if (w < 35) return FUNC_PUSH_FRONT;
         if (w < 70) return FUNC_PUSH_BACK;
         if (w < 78) return FUNC_POP_FRONT;
         if (w < 86) return FUNC_POP_BACK;
         if (w < 92) return FUNC_CONTAINS;
         if (w < 98) return FUNC_REMOVE;
      end else begin
         if (w < 10) return FUNC_PUSH_FRONT;
         if (w < 20) return FUNC_PUSH_BACK;
         if (w < 45) return FUNC_POP_FRONT;
         if (w < 70) return FUNC_POP_BACK;
         if (w < 80) return FUNC_CONTAINS;
         if (w < 98) return FUNC_REMOVE;
      end
      return $urandom_range(1) ? FUNC_RESERVED_7 : FUNC_RESERVED_6;
   endfunction

   initial begin
      int idle_phase[4];
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      idle_pct = 0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      idle_phase = '{0, 78, 16, 0};
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // empty store
      send_word(FUNC_POP_FRONT, 32'h1);
      send_word(FUNC_POP_BACK, 32'h2);
      send_word(FUNC_CONTAINS, 32'h0);
      send_word(FUNC_REMOVE, 32'h0);
      send_word(FUNC_RESERVED_6, 32'h0);
      send_word(FUNC_RESERVED_7, 32'hffff_ffff);
      // extremes at both ends
      send_word(FUNC_PUSH_FRONT, 32'h8000_0000);
      send_word(FUNC_PUSH_BACK, 32'h7fff_ffff);
      send_word(FUNC_CONTAINS, 32'h8000_0000);
      send_word(FUNC_CONTAINS, 32'h7fff_ffff);
      // fill up, with a duplicate value
      for (int i = 0; i < 14; i++) begin
         send_word(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, (i % 7 == 5) ? 32'd5 : 32'(i + 100));
      end
      send_word(FUNC_PUSH_FRONT, 32'hdead_beef);
      send_word(FUNC_PUSH_BACK, 32'hdead_beef);
      send_word(FUNC_CONTAINS, 32'd1234);
      send_word(FUNC_REMOVE, 32'd1234);
      send_word(FUNC_REMOVE, 32'd5);
      send_word(FUNC_REMOVE, 32'h8000_0000);
      send_word(FUNC_REMOVE, 32'h7fff_ffff);
      send_word(FUNC_POP_FRONT, 32'h0);
      send_word(FUNC_POP_BACK, 32'h0);
      send_word(FUNC_RESERVED_7, 32'h0);

      foreach (idle_phase[p]) begin
         idle_pct = idle_phase[p];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_word(pick_func((i / 24) % 2 == 0), pick_value());
         end
      end
      start = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("bounded_deque_bag regression: pass");
      end else begin
         $display("bounded_deque_bag regression: fail");
      end
      $finish;
   end

endmodule
